// ===== rtl/y2bgra_pkg.sv =====
// ----------------------------------------------------------------------------
// y2bgra_pkg: shared types and constants of the YUV 4:2:0 pair to BGRA unit
// Holds the transaction payload structs, the register map, the coefficient
// set and the internal widths of the fixed-point datapath.
// ----------------------------------------------------------------------------
package y2bgra_pkg;

    // Default number of fraction bits of the coefficients.
    localparam int FRAC_BITS_DEFAULT = 14;

    // Product of a 16-bit unsigned coefficient and a 9-bit signed difference.
    localparam int PROD_W = 26;
    // Sum of three products plus the rounding constant.
    localparam int SUM_W  = 28;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register map.
    localparam logic [CFG_INDEX_W-1:0] REG_LUMA_GAIN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LUMA_OFFSET   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_OFFSET = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CB_TO_BLUE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CB_TO_GREEN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CR_TO_GREEN   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CR_TO_RED     = 3'd6;

    localparam logic [15:0] LUMA_GAIN_RESET     = 16'd19077;
    localparam logic [7:0]  LUMA_OFFSET_RESET   = 8'd16;
    localparam logic [7:0]  CHROMA_OFFSET_RESET = 8'd128;
    localparam logic [15:0] CB_TO_BLUE_RESET    = 16'd33050;
    localparam logic [15:0] CB_TO_GREEN_RESET   = 16'd6419;
    localparam logic [15:0] CR_TO_GREEN_RESET   = 16'd13320;
    localparam logic [15:0] CR_TO_RED_RESET     = 16'd26149;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] cb_sample;
        logic [7:0] cr_sample;
        logic       second_present;
    } pair_t;

    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic       second_valid;
        logic [7:0] alpha_value;
    } bgra_t;

    typedef struct packed {
        logic [15:0] luma_gain;
        logic [7:0]  luma_offset;
        logic [7:0]  chroma_offset;
        logic [15:0] cb_to_blue;
        logic [15:0] cb_to_green;
        logic [15:0] cr_to_green;
        logic [15:0] cr_to_red;
    } cfg_t;

    // Chroma contributions shared by both pixels of a pair.
    typedef struct packed {
        logic signed [PROD_W-1:0] blue;
        logic signed [PROD_W-1:0] green_cb;
        logic signed [PROD_W-1:0] green_cr;
        logic signed [PROD_W-1:0] red;
    } chroma_terms_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Pipeline stage enables handed from the top level to the datapath.
    typedef struct packed {
        logic s1_load;
        logic out_load;
    } pipe_ctrl_t;

endpackage

// ===== rtl/y2bgra_chroma.sv =====
// ----------------------------------------------------------------------------
// y2bgra_chroma: chroma product stage
// Removes the chroma zero level from Cb and Cr and registers the four
// coefficient products that both pixel lanes share.
// ----------------------------------------------------------------------------
module y2bgra_chroma
    import y2bgra_pkg::*;
(
    input  logic          clk,
    input  logic          load,
    input  logic [7:0]    cb_sample,
    input  logic [7:0]    cr_sample,
    input  cfg_t          cfg,
    output chroma_terms_t terms
);

    logic signed [8:0]  u;
    logic signed [8:0]  v;
    chroma_terms_t      terms_reg;
    chroma_terms_t      terms_next;

    assign u = $signed({1'b0, cb_sample}) - $signed({1'b0, cfg.chroma_offset});
    assign v = $signed({1'b0, cr_sample}) - $signed({1'b0, cfg.chroma_offset});

    always_comb
    begin
        terms_next.blue     = $signed({1'b0, cfg.cb_to_blue})  * u;
        terms_next.green_cb = $signed({1'b0, cfg.cb_to_green}) * u;
        terms_next.green_cr = $signed({1'b0, cfg.cr_to_green}) * v;
        terms_next.red      = $signed({1'b0, cfg.cr_to_red})   * v;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// ===== rtl/y2bgra_lane.sv =====
// ----------------------------------------------------------------------------
// y2bgra_lane: one pixel lane
// Registers the scaled luma of one pixel, then adds the shared chroma
// terms and rounds and clamps blue, green and red to 8 bits.
// ----------------------------------------------------------------------------
module y2bgra_lane
    import y2bgra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          load,
    input  logic [7:0]    luma,
    input  cfg_t          cfg,
    input  chroma_terms_t terms,
    output pixel_t        pix
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        SUM_W'(1) << (FRAC_BITS - 1);

    logic signed [8:0]        y_diff;
    logic signed [PROD_W-1:0] luma_reg;
    logic signed [PROD_W-1:0] luma_next;
    logic signed [SUM_W-1:0]  luma_ext;
    logic signed [SUM_W-1:0]  blue_sum;
    logic signed [SUM_W-1:0]  green_sum;
    logic signed [SUM_W-1:0]  red_sum;

    // Adds half an LSB, drops the fraction and saturates to 0..255.
    function automatic logic [7:0] round_clamp(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] q;
        t = sum + ROUND_HALF;
        q = t >>> FRAC_BITS;
        if (t[SUM_W-1])
            return 8'd0;
        else if (|q[SUM_W-1:8])
            return 8'hFF;
        else
            return q[7:0];
    endfunction

    assign y_diff    = $signed({1'b0, luma}) - $signed({1'b0, cfg.luma_offset});
    assign luma_next = $signed({1'b0, cfg.luma_gain}) * y_diff;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            luma_reg <= luma_next;
        end
    end

    assign luma_ext  = SUM_W'(luma_reg);
    assign blue_sum  = luma_ext + SUM_W'(terms.blue);
    assign green_sum = luma_ext - SUM_W'(terms.green_cb) - SUM_W'(terms.green_cr);
    assign red_sum   = luma_ext + SUM_W'(terms.red);

    always_comb
    begin
        pix.blue  = round_clamp(blue_sum);
        pix.green = round_clamp(green_sum);
        pix.red   = round_clamp(red_sum);
    end

endmodule

// ===== rtl/y2bgra_merge.sv =====
// ----------------------------------------------------------------------------
// y2bgra_merge: output register
// Combines the two lane results into one BGRA transaction, blanks the right
// pixel of a lone last pixel and adds the constant alpha.
// ----------------------------------------------------------------------------
module y2bgra_merge
    import y2bgra_pkg::*;
(
    input  logic       clk,
    input  pipe_ctrl_t ctrl,
    input  pixel_t     pix_first,
    input  pixel_t     pix_second,
    input  logic       second_present,
    output bgra_t      bgra
);

    bgra_t bgra_reg;
    bgra_t bgra_next;

    always_comb
    begin
        bgra_next.blue_first   = pix_first.blue;
        bgra_next.green_first  = pix_first.green;
        bgra_next.red_first    = pix_first.red;
        bgra_next.blue_second  = second_present ? pix_second.blue  : 8'd0;
        bgra_next.green_second = second_present ? pix_second.green : 8'd0;
        bgra_next.red_second   = second_present ? pix_second.red   : 8'd0;
        bgra_next.second_valid = second_present;
        bgra_next.alpha_value  = ALPHA_OPAQUE;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            bgra_reg <= bgra_next;
        end
    end

    assign bgra = bgra_reg;

endmodule

// ===== rtl/yuv420_pair_to_bgra_unit.sv =====
// ----------------------------------------------------------------------------
// yuv420_pair_to_bgra_unit: fixed-point YUV 4:2:0 to BGRA pixel pair converter
// Converts one horizontal pixel pair (two luma samples, shared Cb and Cr)
// into blue, green, red and alpha for both pixels.
// ----------------------------------------------------------------------------
// Usage:
// The pair channel (pair_valid, pair_ready, pair) carries one pixel pair per
// transaction; the bgra channel (bgra_valid, bgra_ready, bgra) returns exactly
// one result transaction for each pair, in order.
// The unit is a two-stage pipeline: the first stage registers the coefficient
// products (one shared chroma unit and one luma multiplier per pixel lane),
// the second adds, rounds and clamps in both lanes and loads the output
// register. With bgra_ready held high a pair goes through both stages before
// it appears on bgra, and one pair is accepted every cycle.
// When the receiver stalls, the output register holds its transaction and the
// first stage keeps accepting until it is full as well; pair_ready then drops
// until bgra_ready returns.
// Reset empties both stages and loads the default BT.601 coefficient set.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register per
// cycle; indexes above the register map are ignored. Write it only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module yuv420_pair_to_bgra_unit
    import y2bgra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pair_valid,
    output logic                   pair_ready,
    input  pair_t                  pair,
    output logic                   bgra_valid,
    input  logic                   bgra_ready,
    output bgra_t                  bgra
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          second_present_reg;
    pipe_ctrl_t    ctrl;
    logic          s1_free;
    logic          out_free;
    chroma_terms_t terms;
    pixel_t        pix_first;
    pixel_t        pix_second;

    // Configuration registers: one write per cycle, unknown indexes dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LUMA_GAIN:     cfg_next.luma_gain     = cfg_data;
                REG_LUMA_OFFSET:   cfg_next.luma_offset   = cfg_data[7:0];
                REG_CHROMA_OFFSET: cfg_next.chroma_offset = cfg_data[7:0];
                REG_CB_TO_BLUE:    cfg_next.cb_to_blue    = cfg_data;
                REG_CB_TO_GREEN:   cfg_next.cb_to_green   = cfg_data;
                REG_CR_TO_GREEN:   cfg_next.cr_to_green   = cfg_data;
                REG_CR_TO_RED:     cfg_next.cr_to_red     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_gain     <= LUMA_GAIN_RESET;
            cfg_reg.luma_offset   <= LUMA_OFFSET_RESET;
            cfg_reg.chroma_offset <= CHROMA_OFFSET_RESET;
            cfg_reg.cb_to_blue    <= CB_TO_BLUE_RESET;
            cfg_reg.cb_to_green   <= CB_TO_GREEN_RESET;
            cfg_reg.cr_to_green   <= CR_TO_GREEN_RESET;
            cfg_reg.cr_to_red     <= CR_TO_RED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Each stage advances when it is empty or when the stage behind it
    // takes its content, so the pipeline only backs up while bgra stalls.
    assign out_free      = !out_valid_reg || bgra_ready;
    assign s1_free       = !s1_valid_reg || out_free;
    assign pair_ready    = s1_free;
    assign ctrl.s1_load  = s1_free && pair_valid;
    assign ctrl.out_load = out_free && s1_valid_reg;

    assign s1_valid_next  = s1_free  ? pair_valid   : s1_valid_reg;
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The lone-pixel flag travels alongside the first stage products.
    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            second_present_reg <= pair.second_present;
        end
    end

    y2bgra_chroma u_chroma (
        .clk       (clk),
        .load      (ctrl.s1_load),
        .cb_sample (pair.cb_sample),
        .cr_sample (pair.cr_sample),
        .cfg       (cfg_reg),
        .terms     (terms)
    );

    y2bgra_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_first (
        .clk   (clk),
        .load  (ctrl.s1_load),
        .luma  (pair.luma_first),
        .cfg   (cfg_reg),
        .terms (terms),
        .pix   (pix_first)
    );

    y2bgra_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_second (
        .clk   (clk),
        .load  (ctrl.s1_load),
        .luma  (pair.luma_second),
        .cfg   (cfg_reg),
        .terms (terms),
        .pix   (pix_second)
    );

    y2bgra_merge u_merge (
        .clk            (clk),
        .ctrl           (ctrl),
        .pix_first      (pix_first),
        .pix_second     (pix_second),
        .second_present (second_present_reg),
        .bgra           (bgra)
    );

    assign bgra_valid = out_valid_reg;

endmodule

// ===== rtl/y2bgra_checker.sv =====
// ----------------------------------------------------------------------------
// y2bgra_checker: port-level checks of the pair to BGRA unit
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module y2bgra_checker
    import y2bgra_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  pair_valid,
    input logic  pair_ready,
    input logic  bgra_valid,
    input logic  bgra_ready,
    input bgra_t bgra
);

    // A result transaction that is offered stays offered until taken.
    a_bgra_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bgra_valid && !bgra_ready |=> bgra_valid)
        else $error("bgra_valid dropped before the transaction was taken");

    // The unit only backs up the pair channel while a result waits.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pair_ready |-> bgra_valid && !bgra_ready)
        else $error("pair_ready low without a stalled result");

    // A lone last pixel leaves the right pixel blank.
    a_lone_blank: assert property (@(posedge clk) disable iff (!rst_n)
        bgra_valid && !bgra.second_valid |->
            bgra.blue_second == 8'd0 && bgra.green_second == 8'd0 &&
            bgra.red_second == 8'd0)
        else $error("right pixel not blank for a lone last pixel");

    // Alpha is opaque on every result.
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        bgra_valid |-> bgra.alpha_value == ALPHA_OPAQUE)
        else $error("alpha is not opaque");

    // An accepted pair with an idle output and a ready receiver shows up
    // on bgra after the first stage and the output register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && pair_ready && !bgra_valid ##1 bgra_ready |=> bgra_valid)
        else $error("result missing two cycles after an unstalled pair");

endmodule

bind yuv420_pair_to_bgra_unit y2bgra_checker u_y2bgra_checker (.*);
